// File: src/mcmf_pkg.sv
// mcmf_pkg: shared types and constants of the max closure flow solver
// no dependencies

package mcmf_pkg;

    localparam int CMD_W       = 3;
    localparam int NODE_W      = 6;
    localparam int VAL_W       = 32;
    localparam int NET_W       = 38;
    localparam int CNT_W       = 7;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;
    localparam int ACC_W       = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 3'd0,
        CMD_SINK  = 3'd1,
        CMD_SRC   = 3'd2,
        CMD_LINK  = 3'd3,
        CMD_SOLVE = 3'd4
    } t_cmd;

    typedef enum logic {
        REG_LEFT_COUNT  = 1'b0,
        REG_RIGHT_COUNT = 1'b1
    } t_reg;

endpackage

// File: src/max_closure_by_max_flow.sv
// max_closure_by_max_flow: two-layer max closure solved by breadth-first augmenting paths
// depends on mcmf_pkg; all residual state lives in on-chip memories
//
//  channel  | direction | transfer carries
//  s_axis   | in        | tuser: command; tdata: left_node, right_node, edge_value
//  m_axis   | out       | tdata: net_value, one result per solve
//  cfg      | in        | write of left_count (index 0) or right_count (index 1)
//
// sink and source loads write directly; an infinite link does a row read, then a row write
// clear, and the pass right after reset, sweep the link matrix and the node memories
// solve: a search first scans the active right nodes for source capacity, then dequeues nodes;
//   a right node fetches its link row and queues unseen left nodes, a left node scans the unseen
//   right nodes and, with sink capacity left, starts an augment that walks the path back to the
//   source; the final sums add the sink and source-flow memories over the active nodes
// s_axis_tready is high only in idle; a waiting result holds the next solve, and input, at its end

module max_closure_by_max_flow #(
    parameter int LEFT_MAX  = 64,
    parameter int RIGHT_MAX = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // left_node [5:0], right_node [11:6], edge_value [43:12], zero fill
    input  logic [mcmf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // command [2:0]
    input  logic [mcmf_pkg::CMD_W-1:0]         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // net_value [37:0], zero fill
    output logic [mcmf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [mcmf_pkg::CNT_W-1:0]         i_cfg_data
);

    import mcmf_pkg::*;

    localparam int L   = LEFT_MAX;
    localparam int R   = RIGHT_MAX;
    localparam int LB  = (L > 1) ? $clog2(L) : 1;
    localparam int RB  = (R > 1) ? $clog2(R) : 1;
    localparam int MW  = (L > R) ? L : R;
    localparam int MB  = (MW > 1) ? $clog2(MW) : 1;
    localparam int QD  = L + R;
    localparam int QB  = $clog2(QD);
    localparam int QW  = 1 + MB + VAL_W;
    localparam int XB  = LB + RB;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CLEAR, ST_LINK, ST_SSCAN, ST_DEQ, ST_DEQW, ST_RROW, ST_RSCAN,
        ST_LSCAN, ST_AUG0, ST_APL, ST_ARL, ST_APR, ST_ALR, ST_ASRC, ST_SUM, ST_OUT
    } t_state;

    // memories
    logic [VAL_W-1:0] m_lr   [2**XB];
    logic [L-1:0]     m_inf  [2**RB];
    logic [VAL_W-1:0] m_sr   [2**RB];
    logic [VAL_W-1:0] m_rs   [2**RB];
    logic [VAL_W-1:0] m_lt   [2**LB];
    logic [VAL_W-1:0] m_ls   [2**LB];
    logic [RB-1:0]    m_parl [2**LB];
    logic [LB:0]      m_parr [2**RB];
    logic [QW-1:0]    m_q    [QD];

    logic lr_we, lr_re, inf_we, inf_re, sr_we, sr_re, rs_we, rs_re;
    logic lt_we, lt_re, ls_we, ls_re, pl_we, pl_re, pr_we, pr_re, q_we, q_re;
    logic [XB-1:0]    lr_wa, lr_ra;
    logic [RB-1:0]    inf_wa, inf_ra, sr_wa, sr_ra, rs_wa, rs_ra, pr_wa, pr_ra;
    logic [LB-1:0]    lt_wa, lt_ra, ls_wa, ls_ra, pl_wa, pl_ra;
    logic [QB-1:0]    q_wa, q_ra;
    logic [VAL_W-1:0] lr_wd, sr_wd, rs_wd, lt_wd, ls_wd;
    logic [L-1:0]     inf_wd;
    logic [RB-1:0]    pl_wd;
    logic [LB:0]      pr_wd;
    logic [QW-1:0]    q_wd;

    logic [VAL_W-1:0] r_lr_q, r_sr_q, r_rs_q, r_lt_q, r_ls_q;
    logic [L-1:0]     r_inf_q;
    logic [RB-1:0]    r_pl_q;
    logic [LB:0]      r_pr_q;
    logic [QW-1:0]    r_q_q;

    // control state
    t_state           r_state, n_state;
    logic [XB-1:0]    r_clr, n_clr;
    logic [QB:0]      r_head, n_head, r_tail, n_tail;
    logic [MW-1:0]    r_mask, n_mask;
    logic             r_pend, n_pend;
    logic [MB-1:0]    r_pidx, n_pidx;
    logic [MB-1:0]    r_u, n_u;
    logic [RB-1:0]    r_j, n_j;
    logic [VAL_W-1:0] r_m, n_m, r_c, n_c;
    logic [MB:0]      r_k, n_k;
    logic [ACC_W-1:0] r_tot, n_tot, r_flow, n_flow;
    logic [NET_W-1:0] r_odata, n_odata;
    logic             r_ovalid, n_ovalid;
    logic [CNT_W-1:0] r_lcnt, r_rcnt;
    logic [L-1:0]     r_seenl, n_seenl;
    logic [R-1:0]     r_seenr, n_seenr;

    logic             w_acc;
    t_cmd             w_cmd;
    logic [7:0]       w_ln8, w_rn8, w_lc, w_rc;
    logic [VAL_W-1:0] w_val;
    logic [L-1:0]     w_actl;
    logic [R-1:0]     w_actr;
    logic [MB-1:0]    w_low;
    logic [QW-1:0]    w_qe;
    logic [VAL_W-1:0] w_min_lr, w_min_lt;

    function automatic logic [MB-1:0] f_lowest(input logic [MW-1:0] v);
        logic [MB-1:0] r;
        r = '0;
        for (int k = MW - 1; k >= 0; k--) begin
            if (v[k]) r = MB'(k);
        end
        return r;
    endfunction

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_cmd         = t_cmd'(s_axis_tuser);
    assign w_ln8         = {2'b00, s_axis_tdata[5:0]};
    assign w_rn8         = {2'b00, s_axis_tdata[11:6]};
    assign w_val         = s_axis_tdata[43:12];
    assign w_lc          = ({1'b0, r_lcnt} > 8'(L)) ? 8'(L) : {1'b0, r_lcnt};
    assign w_rc          = ({1'b0, r_rcnt} > 8'(R)) ? 8'(R) : {1'b0, r_rcnt};
    assign w_low         = f_lowest(r_mask);
    assign w_qe          = r_q_q;
    assign w_min_lr      = (r_m < r_lr_q) ? r_m : r_lr_q;
    assign w_min_lt      = (r_m < r_lt_q) ? r_m : r_lt_q;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_odata};

    always_comb begin
        for (int i = 0; i < L; i++) w_actl[i] = 8'(i) < w_lc;
        for (int i = 0; i < R; i++) w_actr[i] = 8'(i) < w_rc;
    end

    always_comb begin
        n_state = r_state; n_clr = r_clr; n_head = r_head; n_tail = r_tail;
        n_mask = r_mask; n_pend = r_pend; n_pidx = r_pidx; n_u = r_u; n_j = r_j;
        n_m = r_m; n_c = r_c; n_k = r_k; n_tot = r_tot; n_flow = r_flow;
        n_odata = r_odata; n_seenl = r_seenl; n_seenr = r_seenr;
        n_ovalid = r_ovalid && !m_axis_tready;
        lr_we = 1'b0; lr_re = 1'b0; lr_wa = '0; lr_ra = '0; lr_wd = '0;
        inf_we = 1'b0; inf_re = 1'b0; inf_wa = '0; inf_ra = '0; inf_wd = '0;
        sr_we = 1'b0; sr_re = 1'b0; sr_wa = '0; sr_ra = '0; sr_wd = '0;
        rs_we = 1'b0; rs_re = 1'b0; rs_wa = '0; rs_ra = '0; rs_wd = '0;
        lt_we = 1'b0; lt_re = 1'b0; lt_wa = '0; lt_ra = '0; lt_wd = '0;
        ls_we = 1'b0; ls_re = 1'b0; ls_wa = '0; ls_ra = '0; ls_wd = '0;
        pl_we = 1'b0; pl_re = 1'b0; pl_wa = '0; pl_ra = '0; pl_wd = '0;
        pr_we = 1'b0; pr_re = 1'b0; pr_wa = '0; pr_ra = '0; pr_wd = '0;
        q_we = 1'b0; q_re = 1'b0; q_wa = r_tail[QB-1:0]; q_ra = r_head[QB-1:0]; q_wd = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    case (w_cmd)
                        CMD_CLEAR: begin
                            n_clr   = '0;
                            n_state = ST_CLEAR;
                        end
                        CMD_SINK: begin
                            if (w_ln8 < 8'(L)) begin
                                lt_we = 1'b1; lt_wa = w_ln8[LB-1:0]; lt_wd = w_val;
                                ls_we = 1'b1; ls_wa = w_ln8[LB-1:0]; ls_wd = w_val;
                            end
                        end
                        CMD_SRC: begin
                            if (w_rn8 < 8'(R)) begin
                                sr_we = 1'b1; sr_wa = w_rn8[RB-1:0]; sr_wd = w_val;
                            end
                        end
                        CMD_LINK: begin
                            if (w_ln8 < 8'(L) && w_rn8 < 8'(R)) begin
                                inf_re  = 1'b1;
                                inf_ra  = w_rn8[RB-1:0];
                                n_j     = w_rn8[RB-1:0];
                                n_u     = MB'(w_ln8[LB-1:0]);
                                n_state = ST_LINK;
                            end
                        end
                        CMD_SOLVE: begin
                            n_seenl = '0; n_seenr = '0; n_head = '0; n_tail = '0;
                            n_mask  = MW'(w_actr); n_pend = 1'b0;
                            n_state = ST_SSCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CLEAR: begin
                lr_we = 1'b1; lr_wa = r_clr;
                lt_we = 1'b1; lt_wa = r_clr[XB-1:RB];
                ls_we = 1'b1; ls_wa = r_clr[XB-1:RB];
                sr_we = 1'b1; sr_wa = r_clr[RB-1:0];
                rs_we = 1'b1; rs_wa = r_clr[RB-1:0];
                inf_we = 1'b1; inf_wa = r_clr[RB-1:0];
                n_clr = r_clr + 1'b1;
                if (&r_clr) n_state = ST_IDLE;
            end
            ST_LINK: begin
                inf_we  = 1'b1;
                inf_wa  = r_j;
                inf_wd  = r_inf_q | (L'(1) << r_u[LB-1:0]);
                n_state = ST_IDLE;
            end
            ST_SSCAN: begin
                if (r_pend && r_sr_q != '0) begin
                    q_we = 1'b1; q_wd = {1'b0, r_pidx, r_sr_q}; n_tail = r_tail + 1'b1;
                    n_seenr = r_seenr | (R'(1) << r_pidx[RB-1:0]);
                    pr_we = 1'b1; pr_wa = r_pidx[RB-1:0]; pr_wd = {1'b1, {LB{1'b0}}};
                end
                if (r_mask != '0) begin
                    sr_re = 1'b1; sr_ra = w_low[RB-1:0];
                    n_mask = r_mask & ~(MW'(1) << w_low);
                    n_pend = 1'b1; n_pidx = w_low;
                end else begin
                    n_pend = 1'b0; n_state = ST_DEQ;
                end
            end
            ST_DEQ: begin
                if (r_head == r_tail) begin
                    n_k = '0; n_pend = 1'b0; n_tot = '0; n_flow = '0;
                    n_state = ST_SUM;
                end else begin
                    q_re = 1'b1; n_head = r_head + 1'b1; n_state = ST_DEQW;
                end
            end
            ST_DEQW: begin
                n_u = w_qe[QW-2 -: MB];
                n_m = w_qe[VAL_W-1:0];
                if (w_qe[QW-1]) begin
                    lt_re  = 1'b1; lt_ra = w_qe[VAL_W +: LB];
                    n_mask = MW'(w_actr & ~r_seenr); n_pend = 1'b0;
                    n_state = ST_LSCAN;
                end else begin
                    inf_re = 1'b1; inf_ra = w_qe[VAL_W +: RB];
                    n_state = ST_RROW;
                end
            end
            ST_RROW: begin
                n_mask  = MW'(r_inf_q & w_actl & ~r_seenl);
                n_state = ST_RSCAN;
            end
            ST_RSCAN: begin
                if (r_mask != '0) begin
                    q_we = 1'b1; q_wd = {1'b1, w_low, r_m}; n_tail = r_tail + 1'b1;
                    n_seenl = r_seenl | (L'(1) << w_low[LB-1:0]);
                    pl_we = 1'b1; pl_wa = w_low[LB-1:0]; pl_wd = r_u[RB-1:0];
                    n_mask = r_mask & ~(MW'(1) << w_low);
                end else begin
                    n_state = ST_DEQ;
                end
            end
            ST_LSCAN: begin
                if (r_pend && r_lr_q != '0) begin
                    q_we = 1'b1; q_wd = {1'b0, r_pidx, w_min_lr}; n_tail = r_tail + 1'b1;
                    n_seenr = r_seenr | (R'(1) << r_pidx[RB-1:0]);
                    pr_we = 1'b1; pr_wa = r_pidx[RB-1:0]; pr_wd = {1'b0, r_u[LB-1:0]};
                end
                if (r_mask != '0) begin
                    lr_re = 1'b1; lr_ra = {r_u[LB-1:0], w_low[RB-1:0]};
                    n_mask = r_mask & ~(MW'(1) << w_low);
                    n_pend = 1'b1; n_pidx = w_low;
                end else begin
                    n_pend = 1'b0;
                    if (r_lt_q != '0) begin
                        n_c = w_min_lt; n_state = ST_AUG0;
                    end else begin
                        n_state = ST_DEQ;
                    end
                end
            end
            ST_AUG0: begin
                lt_we = 1'b1; lt_wa = r_u[LB-1:0]; lt_wd = r_lt_q - r_c;
                pl_re = 1'b1; pl_ra = r_u[LB-1:0];
                n_state = ST_APL;
            end
            ST_APL: begin
                n_j = r_pl_q;
                lr_re = 1'b1; lr_ra = {r_u[LB-1:0], r_pl_q};
                n_state = ST_ARL;
            end
            ST_ARL: begin
                lr_we = 1'b1; lr_wa = {r_u[LB-1:0], r_j}; lr_wd = r_lr_q + r_c;
                pr_re = 1'b1; pr_ra = r_j;
                n_state = ST_APR;
            end
            ST_APR: begin
                if (r_pr_q[LB]) begin
                    sr_re = 1'b1; sr_ra = r_j;
                    rs_re = 1'b1; rs_ra = r_j;
                    n_state = ST_ASRC;
                end else begin
                    n_u = MB'(r_pr_q[LB-1:0]);
                    lr_re = 1'b1; lr_ra = {r_pr_q[LB-1:0], r_j};
                    n_state = ST_ALR;
                end
            end
            ST_ALR: begin
                lr_we = 1'b1; lr_wa = {r_u[LB-1:0], r_j}; lr_wd = r_lr_q - r_c;
                pl_re = 1'b1; pl_ra = r_u[LB-1:0];
                n_state = ST_APL;
            end
            ST_ASRC: begin
                sr_we = 1'b1; sr_wa = r_j; sr_wd = r_sr_q - r_c;
                rs_we = 1'b1; rs_wa = r_j; rs_wd = r_rs_q + r_c;
                n_seenl = '0; n_seenr = '0; n_head = '0; n_tail = '0;
                n_mask  = MW'(w_actr); n_pend = 1'b0;
                n_state = ST_SSCAN;
            end
            ST_SUM: begin
                if (r_pend) begin
                    if (8'(r_pidx) < w_lc) n_tot = r_tot + ACC_W'(r_ls_q);
                    if (8'(r_pidx) < w_rc) n_flow = r_flow + ACC_W'(r_rs_q);
                end
                if (r_k < (MB + 1)'(MW)) begin
                    ls_re = 1'b1; ls_ra = r_k[LB-1:0];
                    rs_re = 1'b1; rs_ra = r_k[RB-1:0];
                    n_pidx = r_k[MB-1:0]; n_pend = 1'b1; n_k = r_k + 1'b1;
                end else begin
                    n_pend = 1'b0; n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_odata  = (r_flow > r_tot) ? '0 : NET_W'(r_tot - r_flow);
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
            r_lcnt   <= '0;
            r_rcnt   <= '0;
            r_seenl  <= '0;
            r_seenr  <= '0;
            r_mask   <= '0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
            r_seenl  <= n_seenl;
            r_seenr  <= n_seenr;
            r_mask   <= n_mask;
            if (i_cfg_we) begin
                if (t_reg'(i_cfg_index) == REG_LEFT_COUNT) r_lcnt <= i_cfg_data;
                else r_rcnt <= i_cfg_data;
            end
        end
        r_pidx  <= n_pidx;
        r_u     <= n_u;
        r_j     <= n_j;
        r_m     <= n_m;
        r_c     <= n_c;
        r_k     <= n_k;
        r_tot   <= n_tot;
        r_flow  <= n_flow;
        r_odata <= n_odata;
    end

    always_ff @(posedge i_clk) begin
        if (lr_we) m_lr[lr_wa] <= lr_wd;
        if (lr_re) r_lr_q <= m_lr[lr_ra];
    end

    always_ff @(posedge i_clk) begin
        if (inf_we) m_inf[inf_wa] <= inf_wd;
        if (inf_re) r_inf_q <= m_inf[inf_ra];
    end

    always_ff @(posedge i_clk) begin
        if (sr_we) m_sr[sr_wa] <= sr_wd;
        if (sr_re) r_sr_q <= m_sr[sr_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rs_we) m_rs[rs_wa] <= rs_wd;
        if (rs_re) r_rs_q <= m_rs[rs_ra];
    end

    always_ff @(posedge i_clk) begin
        if (lt_we) m_lt[lt_wa] <= lt_wd;
        if (lt_re) r_lt_q <= m_lt[lt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ls_we) m_ls[ls_wa] <= ls_wd;
        if (ls_re) r_ls_q <= m_ls[ls_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pl_we) m_parl[pl_wa] <= pl_wd;
        if (pl_re) r_pl_q <= m_parl[pl_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pr_we) m_parr[pr_wa] <= pr_wd;
        if (pr_re) r_pr_q <= m_parr[pr_ra];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) m_q[q_wa] <= q_wd;
        if (q_re) r_q_q <= m_q[q_ra];
    end

`ifndef NO_ASSERTIONS
    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= (QB + 1)'(QD))
        else $error("search queue overflow");

    a_head_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("queue head passed tail");

    a_left_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RSCAN && r_mask != '0) |-> !r_seenl[w_low[LB-1:0]])
        else $error("left node queued twice in one search");

    a_busy_solve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SSCAN) |-> !s_axis_tready)
        else $error("input taken during a search");
`endif

endmodule

// File: tb/tb_flow_checker.sv
// tb_flow_checker: watches the load, result and register channels of the max closure solver,
// predicts each solve result with its own max flow model and compares it with the block
// depends on mcmf_pkg
`timescale 1ns / 1ps

module tb_flow_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [mcmf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [mcmf_pkg::CMD_W-1:0]       s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [mcmf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_index,
    input  logic [mcmf_pkg::CNT_W-1:0]       i_cfg_data,
    output int                               o_errors,
    output int                               o_pending,
    output int                               o_results
);

    import mcmf_pkg::*;

    localparam int LM   = 64;
    localparam int RM   = 64;
    localparam int NN   = LM + RM + 2;
    localparam int SNK  = LM + RM + 1;
    localparam logic [63:0] UNBOUNDED = 64'h1_0000_0000;

    logic [VAL_W-1:0] resid    [NN*NN];
    bit               link_on  [NN*NN];
    logic [VAL_W-1:0] sink_cap [LM];
    logic [CNT_W-1:0] left_cnt;
    logic [CNT_W-1:0] right_cnt;
    logic [NET_W-1:0] net_q [$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_results = 0;
    end

    task automatic wipe_network();
        for (int k = 0; k < NN*NN; k++) begin
            resid[k]   = '0;
            link_on[k] = 1'b0;
        end
        for (int k = 0; k < LM; k++) sink_cap[k] = '0;
    endtask

    function automatic bit node_on(int k, int lc, int rc);
        if (k == 0 || k == SNK) return 1'b1;
        if (k <= LM) return (k - 1) < lc;
        return (k - 1 - LM) < rc;
    endfunction

    // one breadth-first search and augment, returns 0 when no path is left
    function automatic bit push_path(int lc, int rc);
        bit          seen [NN];
        int          par  [NN];
        int          qn   [NN];
        logic [63:0] qb   [NN];
        int          head;
        int          tail;
        int          u;
        int          v;
        int          p;
        int          steps;
        int          e;
        logic [63:0] m;
        logic [63:0] cap;
        logic [31:0] c;
        for (int k = 0; k < NN; k++) begin
            seen[k] = 1'b0;
            par[k]  = 0;
        end
        head = 0;
        tail = 1;
        qn[0] = 0;
        qb[0] = UNBOUNDED;
        seen[0] = 1'b1;
        while (head < tail) begin
            u = qn[head];
            m = qb[head];
            head++;
            if (u == SNK) begin
                c = m[31:0];
                v = u;
                steps = 0;
                while (v != 0 && steps < NN) begin
                    p = par[v];
                    if (!link_on[v*NN + p]) resid[v*NN + p] = resid[v*NN + p] + c;
                    if (!link_on[p*NN + v]) resid[p*NN + v] = resid[p*NN + v] - c;
                    v = p;
                    steps++;
                end
                return 1'b1;
            end
            for (int i = 0; i < NN; i++) begin
                e = u*NN + i;
                if (seen[i] || !node_on(i, lc, rc)) continue;
                if (!link_on[e] && resid[e] == '0) continue;
                cap = link_on[e] ? UNBOUNDED : {32'd0, resid[e]};
                seen[i] = 1'b1;
                par[i] = u;
                if (tail < NN) begin
                    qn[tail] = i;
                    qb[tail] = (m < cap) ? m : cap;
                    tail++;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [NET_W-1:0] closure_value();
        int          lc;
        int          rc;
        logic [63:0] flow;
        logic [63:0] total;
        logic [63:0] diff;
        lc = (left_cnt > LM) ? LM : int'(left_cnt);
        rc = (right_cnt > RM) ? RM : int'(right_cnt);
        while (push_path(lc, rc)) ;
        flow = '0;
        total = '0;
        for (int i = 0; i < lc; i++) total += sink_cap[i];
        for (int i = 0; i < rc; i++) flow += resid[(1 + LM + i)*NN];
        diff = (flow > total) ? 64'd0 : total - flow;
        return diff[NET_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        logic [5:0]       ln;
        logic [5:0]       rn;
        logic [31:0]      val;
        logic [NET_W-1:0] want;
        if (!i_rst_n) begin
            wipe_network();
            left_cnt = '0;
            right_cnt = '0;
            net_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_reg'(i_cfg_index))
                    REG_LEFT_COUNT:  left_cnt = i_cfg_data;
                    REG_RIGHT_COUNT: right_cnt = i_cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                o_results++;
                if (net_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("error: unexpected result net_value=%0d", m_axis_tdata[NET_W-1:0]);
                end else begin
                    want = net_q.pop_front();
                    if (m_axis_tdata[NET_W-1:0] !== want) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("error: net_value expected %0d got %0d", want,
                                     m_axis_tdata[NET_W-1:0]);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                ln  = s_axis_tdata[5:0];
                rn  = s_axis_tdata[11:6];
                val = s_axis_tdata[43:12];
                case (t_cmd'(s_axis_tuser))
                    CMD_CLEAR: wipe_network();
                    CMD_SINK: begin
                        resid[(1 + ln)*NN + SNK] = val;
                        sink_cap[ln] = val;
                    end
                    CMD_SRC:   resid[1 + LM + rn] = val;
                    CMD_LINK:  link_on[(1 + LM + rn)*NN + 1 + ln] = 1'b1;
                    CMD_SOLVE: net_q.push_back(closure_value());
                    default: ;
                endcase
            end
        end
        o_pending = net_q.size();
    end

endmodule

// File: tb/tb_top.sv
// tb_top: drives loads, solves and count writes into the max closure solver in bursts,
// with a stalling result receiver; results are checked by tb_flow_checker
// depends on mcmf_pkg, max_closure_by_max_flow and tb_flow_checker
`timescale 1ns / 1ps

module tb_top;
    import mcmf_pkg::*;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_data = '0;
    logic [CMD_W-1:0]       s_user = '0;
    logic                   m_axis_tvalid;
    logic                   m_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we = 1'b0;
    logic                   cfg_index = 1'b0;
    logic [CNT_W-1:0]       cfg_data = '0;

    int   err_cnt;
    int   pending;
    int   result_cnt;
    int   item_cnt = 0;
    int   setting_cnt = 0;
    int   burst_left = 0;
    int   idle_cyc = 0;
    logic stall_tog = 1'b0;
    logic stall_seen = 1'b0;
    int   stall_left = 0;
    logic [15:0] rcv_cyc = '0;

    always #5 i_clk = ~i_clk;

    max_closure_by_max_flow DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    tb_flow_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_errors      (err_cnt),
        .o_pending     (pending),
        .o_results     (result_cnt)
    );

    // result receiver: long hold on request, otherwise a pattern chosen by bits 9:8 of a free-running counter
    always @(posedge i_clk) begin
        rcv_cyc <= rcv_cyc + 1'b1;
        if (stall_tog != stall_seen) begin
            stall_seen <= stall_tog;
            stall_left <= 400;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            case (rcv_cyc[9:8])
                2'd0: m_ready <= 1'b1;
                2'd1: m_ready <= 1'($urandom_range(0, 1));
                2'd2: m_ready <= (rcv_cyc[2:0] < 3'd3);
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready) || cfg_we)
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= 300000) begin
            $display("timeout: no transfer for %0d cycles", idle_cyc);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic put_item(input logic [CMD_W-1:0] cmd, input logic [5:0] ln,
                            input logic [5:0] rn, input logic [31:0] val);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 24);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_user <= cmd;
        s_data <= {4'b0, val, rn, ln};
        @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
        item_cnt++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_counts(input logic [CNT_W-1:0] lc, input logic [CNT_W-1:0] rc);
        cfg_we <= 1'b1;
        cfg_index <= REG_LEFT_COUNT;
        cfg_data <= lc;
        @(posedge i_clk);
        cfg_index <= REG_RIGHT_COUNT;
        cfg_data <= rc;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        setting_cnt++;
    endtask

    function automatic logic [5:0] pick_node(int n);
        if (n == 0 || $urandom_range(0, 7) == 0) return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, ((n > 64) ? 64 : n) - 1));
    endfunction

    function automatic logic [31:0] pick_val();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF;
            1: return 32'd0;
            2: return 32'($urandom_range(1, 20));
            default: return $urandom;
        endcase
    endfunction

    task automatic run_phase(input int lc, input int rc, input int nload);
        int r;
        wait_idle();
        set_counts(CNT_W'(lc), CNT_W'(rc));
        if ($urandom_range(0, 5) != 0) put_item(CMD_CLEAR, '0, '0, '0);
        for (int k = 0; k < nload; k++) begin
            r = $urandom_range(0, 99);
            if (r < 30)
                put_item(CMD_SINK, pick_node(lc), 6'($urandom), pick_val());
            else if (r < 60)
                put_item(CMD_SRC, 6'($urandom), pick_node(rc), pick_val());
            else if (r < 85)
                put_item(CMD_LINK, pick_node(lc), pick_node(rc), $urandom);
            else if (r < 91)
                put_item(CMD_SOLVE, 6'($urandom), 6'($urandom), $urandom);
            else
                put_item(3'($urandom), 6'($urandom), 6'($urandom), $urandom);
        end
        put_item(CMD_SOLVE, 6'($urandom), 6'($urandom), $urandom);
    endtask

    initial begin
        int lc;
        int rc;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every command, unknown commands, reloads, saturation
        set_counts(7'd3, 7'd2);
        put_item(CMD_CLEAR, '0, '0, '0);
        put_item(CMD_SINK, 6'd0, '0, 32'hFFFF_FFFF);
        put_item(CMD_SINK, 6'd1, '0, 32'd5);
        put_item(CMD_SINK, 6'd2, '0, 32'd0);
        put_item(CMD_SRC, '0, 6'd0, 32'hFFFF_FFFF);
        put_item(CMD_SRC, '0, 6'd1, 32'd7);
        put_item(CMD_LINK, 6'd0, 6'd0, '0);
        put_item(CMD_LINK, 6'd1, 6'd1, '0);
        put_item(CMD_LINK, 6'd2, 6'd1, '0);
        put_item(CMD_SOLVE + 3'd1, 6'd63, 6'd63, 32'hFFFF_FFFF);
        put_item(CMD_SOLVE + 3'd2, '0, '0, '0);
        put_item(CMD_SOLVE + 3'd3, 6'd1, 6'd1, 32'd1);
        put_item(CMD_SINK, 6'd63, '0, 32'd9);
        put_item(CMD_SRC, '0, 6'd63, 32'd3);
        put_item(CMD_LINK, 6'd63, 6'd63, '0);
        put_item(CMD_SOLVE, '0, '0, '0);
        put_item(CMD_SINK, 6'd1, '0, 32'd2);
        put_item(CMD_SOLVE, '0, '0, '0);
        wait_idle();
        set_counts(7'd64, 7'd64);
        put_item(CMD_SOLVE, '0, '0, '0);
        wait_idle();
        set_counts(7'd127, 7'd0);
        put_item(CMD_SOLVE, '0, '0, '0);
        wait_idle();
        set_counts(7'd0, 7'd3);
        put_item(CMD_SOLVE, '0, '0, '0);

        // receiver holds off while solves and loads keep coming
        wait_idle();
        set_counts(7'd4, 7'd4);
        stall_tog <= ~stall_tog;
        put_item(CMD_SOLVE, '0, '0, '0);
        put_item(CMD_SRC, '0, 6'd2, 32'd11);
        put_item(CMD_SINK, 6'd3, '0, 32'd13);
        put_item(CMD_LINK, 6'd3, 6'd2, '0);
        put_item(CMD_SOLVE, '0, '0, '0);
        put_item(CMD_SOLVE, '0, '0, '0);

        while (item_cnt < 380) begin
            case ($urandom_range(0, 9))
                0: begin
                    lc = ($urandom_range(0, 1) == 0) ? 64 : $urandom_range(65, 127);
                    rc = ($urandom_range(0, 2) == 0) ? 0 : 64;
                    run_phase(lc, rc, $urandom_range(4, 20));
                end
                1: run_phase($urandom_range(9, 20), $urandom_range(9, 20),
                             $urandom_range(10, 30));
                default: run_phase($urandom_range(1, 8), $urandom_range(1, 8),
                                   $urandom_range(4, 24));
            endcase
        end

        wait_idle();
        repeat (50) @(posedge i_clk);
        $display("run covered %0d input transfers, %0d solve results, %0d count settings",
                 item_cnt, result_cnt, setting_cnt);
        if (err_cnt == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("errors %0d, results still awaited %0d", err_cnt, pending);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
src/mcmf_pkg.sv
src/max_closure_by_max_flow.sv
tb/tb_flow_checker.sv
tb/tb_top.sv
